>>> sv/crd_pkg.sv
// shared types, constants and the crc byte update of the checked record decoder
package crd_pkg;

  localparam int unsigned POS_W = 18;
  localparam int unsigned LEN_W = POS_W + 1;
  localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

  // byte offsets inside a record
  localparam logic [POS_W-1:0] OFS_VERSION  = POS_W'(4);
  localparam logic [POS_W-1:0] OFS_COLOR    = POS_W'(5);
  localparam logic [POS_W-1:0] OFS_COUNT_LO = POS_W'(6);
  localparam logic [POS_W-1:0] OFS_COUNT_HI = POS_W'(7);
  localparam logic [POS_W-1:0] OFS_GEN      = POS_W'(8);
  localparam logic [POS_W-1:0] OFS_SEED     = POS_W'(12);
  localparam logic [POS_W-1:0] HEADER_BYTES = POS_W'(20);
  localparam logic [POS_W-1:0] CHECK_BYTES  = POS_W'(4);
  localparam logic [LEN_W-1:0] MIN_LEN      = LEN_W'(24);

  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] CRC_ONES = 32'hFFFF_FFFF;

  // fault flag bits
  localparam int unsigned FLT_W       = 4;
  localparam int unsigned FLT_MAGIC   = 0;
  localparam int unsigned FLT_VERSION = 1;
  localparam int unsigned FLT_COLOR   = 2;
  localparam int unsigned FLT_COUNT   = 3;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [7:0]  FORMAT_VERSION_RST = 8'd1;
  localparam logic [15:0] MAX_MOVES_RST      = 16'd512;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FORMAT_VERSION = 1'b0,
    CFG_MAX_MOVES      = 1'b1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_LENGTH  = 3'd1,
    ST_MAGIC   = 3'd2,
    ST_VERSION = 3'd3,
    ST_COLOR   = 3'd4,
    ST_COUNT   = 3'd5,
    ST_CRC     = 3'd6
  } status_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_record;
  } in_beat_t;

  typedef struct packed {
    logic        is_verdict;
    logic [15:0] move_word;
    logic [15:0] move_index;
    logic        player_color;
    logic [15:0] move_total;
    logic [31:0] generation_value;
    logic [63:0] seed_value;
    logic [2:0]  status;
    logic        final_flag;
  } res_beat_t;

  // expected magic byte at offsets zero to three
  function automatic logic [7:0] magic_byte(input logic [1:0] idx);
    logic [7:0] m;
    case (idx)
      2'd0:    m = 8'h43;
      2'd1:    m = 8'h50;
      2'd2:    m = 8'h43;
      default: m = 8'h48;
    endcase
    return m;
  endfunction

  // reflected crc-32, one byte
  function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
    logic [31:0] c;
    c = c_in ^ {24'h0, b};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
    end
    return c;
  endfunction

endpackage

>>> sv/crd_stream_if.sv
// valid/ready stream channel with a typed payload
interface crd_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

>>> sv/crc_checked_record_decoder.sv
// top level of the crc checked record decoder
//
// in_if carries one record byte per beat, with end_of_record set on the final
// byte. out_if carries at most one result beat per input beat: a move word as
// soon as its second byte arrives (while no header fault is latched and the
// word lies within the move count), or the verdict with the header fields and
// a status on the final byte. downstream commits the moves on status zero only.
// the config port (cfg_we_i, cfg_idx_i, cfg_data_i) writes format_version
// (index 0) and max_moves (index 1); write it only while the block is idle.
// a byte waits in the input register; its result is held in the result register.
// throughput: one byte per cycle while the receiver takes results; the crc byte
// update and the verdict compare sit between the input register and the result register.
// reset clears the record state (crc to all ones, fields to zero) and sets the
// config registers to version 1 and 512 moves; both channels come up empty.
// when the receiver stalls, the result register holds its beat, the input
// register still takes one more byte if it is empty, and then ready drops
// until the result is taken.
module crc_checked_record_decoder (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [crd_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [crd_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  crd_stream_if.sink                      in_if,
  crd_stream_if.source                    out_if
);

  logic               in_valid;
  crd_pkg::in_beat_t  in_beat;
  logic               out_free;
  logic               step;
  logic               res_valid;
  crd_pkg::res_beat_t res;

  // a byte moves from the input register into the parser when the result
  // register can take whatever it produces
  assign step = in_valid && out_free;

  crd_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_if   (in_if),
    .step_i  (step),
    .valid_o (in_valid),
    .beat_o  (in_beat)
  );

  crd_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .step_i      (step),
    .beat_i      (in_beat),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  crd_out_reg u_out_reg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (step && res_valid),
    .res_i  (res),
    .free_o (out_free),
    .out_if (out_if)
  );

  // a verdict beat and only a verdict beat carries the final flag
  a_final_is_verdict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid |-> out_if.payload.final_flag == out_if.payload.is_verdict)
    else $error("final flag and verdict marker disagree");

  // move beats report status zero
  a_move_status_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && !out_if.payload.is_verdict |-> out_if.payload.status == crd_pkg::ST_OK)
    else $error("move beat with nonzero status");

  // a held byte stalls only behind a result the receiver has not taken
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && !step |-> out_if.valid && !out_if.ready)
    else $error("input stalled without an output stall");

  // a result produced while the output is busy would be lost
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && res_valid |-> !out_if.valid || out_if.ready)
    else $error("result register overwritten");

endmodule

>>> sv/crd_in_reg.sv
// input register stage of the record decoder
module crd_in_reg (
  input  logic               clk_i,
  input  logic               rst_ni,
  crd_stream_if.sink         in_if,
  input  logic               step_i,
  output logic               valid_o,
  output crd_pkg::in_beat_t  beat_o
);

  logic              valid_q, valid_d;
  crd_pkg::in_beat_t beat_q;
  logic              take;

  assign in_if.ready = !valid_q || step_i;
  assign take        = in_if.valid && in_if.ready;

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (step_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      beat_q <= in_if.payload;
    end
  end

  assign valid_o = valid_q;
  assign beat_o  = beat_q;

endmodule

>>> sv/crd_parser.sv
// record state, field capture, crc and verdict logic
module crd_parser (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [crd_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [crd_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                                step_i,
  input  crd_pkg::in_beat_t                   beat_i,
  output logic                                res_valid_o,
  output crd_pkg::res_beat_t                  res_o
);

  logic [7:0]  fmt_ver_q;
  logic [15:0] max_moves_q;

  logic [crd_pkg::POS_W-1:0] pos_q, pos_d;
  logic [31:0]               crc_q, crc_d, crc_n;
  logic [31:0]               trail_q, trail_d, trail_n;
  logic [15:0]               count_q, count_d, count_n;
  logic [31:0]               gen_q, gen_d, gen_n;
  logic [63:0]               seed_q, seed_d, seed_n;
  logic                      color_q, color_d, color_n;
  logic [7:0]                low_q, low_d, low_n;
  logic [crd_pkg::FLT_W-1:0] fault_q, fault_d, fault_n;

  logic [7:0]                b;
  logic                      last;
  logic [crd_pkg::POS_W-1:0] body_ofs;
  logic [16:0]               idx;
  logic [2:0]                seed_lane;
  logic                      emit_move;
  logic [crd_pkg::LEN_W-1:0] len;
  logic [crd_pkg::LEN_W-1:0] expect_len;
  crd_pkg::status_e          st;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_ver_q   <= crd_pkg::FORMAT_VERSION_RST;
      max_moves_q <= crd_pkg::MAX_MOVES_RST;
    end else if (cfg_we_i) begin
      case (crd_pkg::cfg_reg_e'(cfg_idx_i))
        crd_pkg::CFG_FORMAT_VERSION: fmt_ver_q   <= cfg_data_i[7:0];
        crd_pkg::CFG_MAX_MOVES:      max_moves_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  assign b         = beat_i.data_byte;
  assign last      = beat_i.end_of_record;
  assign body_ofs  = pos_q - crd_pkg::HEADER_BYTES;
  assign idx       = body_ofs[crd_pkg::POS_W-1:1];
  assign seed_lane = pos_q[2:0] + 3'd4;

  // field capture and fault latching
  always_comb begin
    crc_n     = (pos_q >= crd_pkg::CHECK_BYTES) ? crd_pkg::crc_byte(crc_q, trail_q[7:0]) : crc_q;
    trail_n   = {b, trail_q[31:8]};
    count_n   = count_q;
    gen_n     = gen_q;
    seed_n    = seed_q;
    color_n   = color_q;
    low_n     = low_q;
    fault_n   = fault_q;
    emit_move = 1'b0;

    if (pos_q < crd_pkg::OFS_VERSION) begin
      if (b != crd_pkg::magic_byte(pos_q[1:0])) begin
        fault_n[crd_pkg::FLT_MAGIC] = 1'b1;
      end
    end else if (pos_q == crd_pkg::OFS_VERSION) begin
      if (b != fmt_ver_q) begin
        fault_n[crd_pkg::FLT_VERSION] = 1'b1;
      end
    end else if (pos_q == crd_pkg::OFS_COLOR) begin
      if (b > 8'd1) begin
        fault_n[crd_pkg::FLT_COLOR] = 1'b1;
      end
      color_n = b[0];
    end else if (pos_q == crd_pkg::OFS_COUNT_LO) begin
      count_n = {8'h00, b};
    end else if (pos_q == crd_pkg::OFS_COUNT_HI) begin
      count_n = {b, count_q[7:0]};
      if (count_n > max_moves_q) begin
        fault_n[crd_pkg::FLT_COUNT] = 1'b1;
      end
    end else if (pos_q < crd_pkg::OFS_SEED) begin
      gen_n[{pos_q[1:0], 3'b000} +: 8] = gen_q[{pos_q[1:0], 3'b000} +: 8] | b;
    end else if (pos_q < crd_pkg::HEADER_BYTES) begin
      seed_n[{seed_lane, 3'b000} +: 8] = seed_q[{seed_lane, 3'b000} +: 8] | b;
    end else if (!body_ofs[0]) begin
      low_n = b;
    end else if (!last && (fault_q == '0)) begin
      emit_move = (idx < {1'b0, count_q});
    end
  end

  // verdict
  always_comb begin
    len        = {1'b0, pos_q} + crd_pkg::LEN_W'(1);
    expect_len = crd_pkg::LEN_W'(crd_pkg::HEADER_BYTES + crd_pkg::CHECK_BYTES)
               + {2'b00, count_n, 1'b0};
    if (len < crd_pkg::MIN_LEN) begin
      st = crd_pkg::ST_LENGTH;
    end else if (fault_n[crd_pkg::FLT_MAGIC]) begin
      st = crd_pkg::ST_MAGIC;
    end else if (fault_n[crd_pkg::FLT_VERSION]) begin
      st = crd_pkg::ST_VERSION;
    end else if (fault_n[crd_pkg::FLT_COLOR]) begin
      st = crd_pkg::ST_COLOR;
    end else if (fault_n[crd_pkg::FLT_COUNT]) begin
      st = crd_pkg::ST_COUNT;
    end else if (len != expect_len) begin
      st = crd_pkg::ST_LENGTH;
    end else if (~crc_n != trail_n) begin
      st = crd_pkg::ST_CRC;
    end else begin
      st = crd_pkg::ST_OK;
    end
  end

  // result beat
  always_comb begin
    res_valid_o             = emit_move || last;
    res_o.is_verdict        = last;
    res_o.move_word         = last ? 16'h0000 : {b, low_q};
    res_o.move_index        = last ? 16'h0000 : idx[15:0];
    res_o.player_color      = color_n;
    res_o.move_total        = count_n;
    res_o.generation_value  = gen_n;
    res_o.seed_value        = seed_n;
    res_o.status            = last ? st : crd_pkg::ST_OK;
    res_o.final_flag        = last;
  end

  // next record state, cleared after the final byte
  always_comb begin
    pos_d   = (pos_q == crd_pkg::POS_MAX) ? pos_q : pos_q + crd_pkg::POS_W'(1);
    crc_d   = crc_n;
    trail_d = trail_n;
    count_d = count_n;
    gen_d   = gen_n;
    seed_d  = seed_n;
    color_d = color_n;
    low_d   = low_n;
    fault_d = fault_n;
    if (last) begin
      pos_d   = '0;
      crc_d   = crd_pkg::CRC_ONES;
      trail_d = '0;
      count_d = '0;
      gen_d   = '0;
      seed_d  = '0;
      color_d = 1'b0;
      low_d   = '0;
      fault_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      crc_q   <= crd_pkg::CRC_ONES;
      trail_q <= '0;
      count_q <= '0;
      gen_q   <= '0;
      seed_q  <= '0;
      color_q <= 1'b0;
      low_q   <= '0;
      fault_q <= '0;
    end else if (step_i) begin
      pos_q   <= pos_d;
      crc_q   <= crc_d;
      trail_q <= trail_d;
      count_q <= count_d;
      gen_q   <= gen_d;
      seed_q  <= seed_d;
      color_q <= color_d;
      low_q   <= low_d;
      fault_q <= fault_d;
    end
  end

  a_clear_after_verdict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && last |=> pos_q == '0 && fault_q == '0 && crc_q == crd_pkg::CRC_ONES)
    else $error("record state not cleared after final byte");

  a_no_move_on_fault: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_move |-> fault_q == '0 && !last)
    else $error("move emitted with a latched fault");

  a_move_in_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_move |-> {1'b0, res_o.move_index} < {1'b0, count_q})
    else $error("move index beyond move count");

endmodule

>>> sv/crd_out_reg.sv
// result register driving the output channel
module crd_out_reg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  crd_pkg::res_beat_t res_i,
  output logic               free_o,
  crd_stream_if.source       out_if
);

  logic               valid_q, valid_d;
  crd_pkg::res_beat_t res_q;

  assign free_o = !valid_q || out_if.ready;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_if.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_if.valid   = valid_q;
  assign out_if.payload = res_q;

endmodule

>>> tb/testbench.sv
// self-checking testbench for the crc checked record decoder
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import crd_pkg::*;

  // quiet cycles (no beat on either channel) before the run is declared hung
  localparam int unsigned QUIET_LIMIT = 1000;
  // receiver hold-off used to back the block up into its input
  localparam int unsigned HOLD_CYCLES = 250;
  // random bytes per configuration phase
  localparam int unsigned PHASE_BYTES = 300;
  // long enough to run the byte counter into saturation
  localparam int unsigned LONG_RECORD_BYTES = 262150;

  // shapes of record that the generator can build
  typedef enum int {
    REC_GOOD,       // well formed, crc correct
    REC_SHORT,      // cut below the minimum length
    REC_MAGIC,      // one magic byte wrong
    REC_VERSION,    // version byte differs from format_version
    REC_COLOR,      // color byte above one
    REC_COUNT,      // move count above max_moves
    REC_MULTI,      // magic, version, color (and count) all wrong
    REC_SURPLUS,    // extra bytes after the checksum
    REC_MOVE_LAST,  // checksum left off, last move word ends the record
    REC_CRC,        // one bit flipped after the checksum was computed
    REC_TRUNC,      // header count at or above the move words present
    REC_NOISE,      // random bytes of random length
    REC_LONG        // good header, then far too many bytes
  } rec_kind_e;

  typedef enum int {
    FILL_ZERO,
    FILL_ONES,
    FILL_RAND
  } fill_e;

  typedef struct {
    rec_kind_e kind;
    int        n;        // move words, or total length for a short record
    fill_e     fill;
    status_e   verdict;  // status read straight off the record shape
  } plan_row_t;

  // directed records, all under the reset configuration (version 1, 512 moves)
  plan_row_t directed_plan[13] = '{
    '{REC_GOOD,      0,  FILL_ZERO, ST_OK},
    '{REC_GOOD,      2,  FILL_ONES, ST_OK},
    '{REC_GOOD,      3,  FILL_RAND, ST_OK},
    '{REC_SHORT,     1,  FILL_RAND, ST_LENGTH},
    '{REC_SHORT,     23, FILL_ONES, ST_LENGTH},
    '{REC_MAGIC,     1,  FILL_RAND, ST_MAGIC},
    '{REC_VERSION,   1,  FILL_RAND, ST_VERSION},
    '{REC_COLOR,     1,  FILL_RAND, ST_COLOR},
    '{REC_COUNT,     1,  FILL_ONES, ST_COUNT},
    '{REC_MULTI,     1,  FILL_RAND, ST_MAGIC},
    '{REC_SURPLUS,   2,  FILL_RAND, ST_LENGTH},
    '{REC_MOVE_LAST, 2,  FILL_RAND, ST_LENGTH},
    '{REC_CRC,       2,  FILL_RAND, ST_CRC}
  };

  logic [7:0] record_magic [4] = '{8'h43, 8'h50, 8'h43, 8'h48};

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we;
  cfg_reg_e              cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  crd_stream_if #(.payload_t(in_beat_t))  in_ch ();
  crd_stream_if #(.payload_t(res_beat_t)) out_ch ();

  crc_checked_record_decoder DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_if      (in_ch),
    .out_if     (out_ch)
  );

  // decoder model: configuration copy and per-record state
  logic [7:0]       model_version;
  logic [15:0]      model_max_moves;
  logic [POS_W-1:0] rec_pos;
  logic [31:0]      rec_crc;
  logic [31:0]      rec_tail;
  logic [15:0]      rec_count;
  logic [31:0]      rec_gen;
  logic [63:0]      rec_seed;
  logic             rec_color;
  logic [7:0]       rec_low;
  logic [FLT_W-1:0] rec_faults;

  res_beat_t  expected_results [$];
  logic [7:0] record_bytes [$];

  int  err_count = 0;
  int  bytes_sent = 0;
  int  records_sent = 0;
  int  beats_checked = 0;
  int  moves_checked = 0;
  int  verdict_mix [8] = '{default: 0};
  int  quiet_cycles = 0;
  bit  tx_idle = 1'b1;
  bit  rx_idle = 1'b1;
  bit  hold_req = 1'b0;

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // reflected crc-32, one bit at a time with the data bit folded into the feedback
  function automatic logic [31:0] crc_next(input logic [31:0] c, input logic [7:0] d);
    logic [31:0] r;
    r = c;
    for (int i = 0; i < 8; i++) begin
      if (r[0] ^ d[i]) r = (r >> 1) ^ CRC_POLY;
      else r = r >> 1;
    end
    return r;
  endfunction

  function automatic logic [7:0] fill_byte(input fill_e fill);
    logic [7:0] b;
    case (fill)
      FILL_ZERO: b = 8'h00;
      FILL_ONES: b = 8'hFF;
      default:   b = 8'($urandom_range(0, 255));
    endcase
    return b;
  endfunction

  task automatic clear_record_model();
    rec_pos    = '0;
    rec_crc    = CRC_ONES;
    rec_tail   = '0;
    rec_count  = '0;
    rec_gen    = '0;
    rec_seed   = '0;
    rec_color  = 1'b0;
    rec_low    = '0;
    rec_faults = '0;
  endtask

  // work out the result beat (if any) one accepted byte causes
  task automatic predict_beat(input logic [7:0] b, input logic last,
                              output bit produced, output res_beat_t r);
    logic [POS_W-1:0] p;
    logic [POS_W-1:0] rel;
    logic [LEN_W-1:0] len;
    logic [LEN_W-1:0] want_len;
    int               k;
    p = rec_pos;
    r = '0;
    produced = 1'b0;
    // the crc only covers bytes that have left the four-byte trailer window
    if (p >= CHECK_BYTES) rec_crc = crc_next(rec_crc, rec_tail[7:0]);
    rec_tail = {b, rec_tail[31:8]};
    k = int'(p);
    if (k < 4) begin
      if (b != record_magic[k]) rec_faults[FLT_MAGIC] = 1'b1;
    end else if (p == OFS_VERSION) begin
      if (b != model_version) rec_faults[FLT_VERSION] = 1'b1;
    end else if (p == OFS_COLOR) begin
      if (b > 8'd1) rec_faults[FLT_COLOR] = 1'b1;
      rec_color = b[0];
    end else if (p == OFS_COUNT_LO) begin
      rec_count = {8'h00, b};
    end else if (p == OFS_COUNT_HI) begin
      rec_count[15:8] = b;
      if (rec_count > model_max_moves) rec_faults[FLT_COUNT] = 1'b1;
    end else if (p < OFS_SEED) begin
      rec_gen[8*(k-8) +: 8] = b;
    end else if (p < HEADER_BYTES) begin
      rec_seed[8*(k-12) +: 8] = b;
    end else begin
      rel = p - HEADER_BYTES;
      if (!rel[0]) begin
        rec_low = b;
      end else if (!last && rec_faults == '0 && (rel >> 1) < rec_count) begin
        produced     = 1'b1;
        r.move_word  = {b, rec_low};
        r.move_index = rel[16:1];
      end
    end
    if (rec_pos != POS_MAX) rec_pos = rec_pos + 1'b1;
    if (produced || last) begin
      r.player_color     = rec_color;
      r.move_total       = rec_count;
      r.generation_value = rec_gen;
      r.seed_value       = rec_seed;
    end
    if (last) begin
      len      = {1'b0, p} + 1'b1;
      want_len = MIN_LEN + {rec_count, 1'b0};
      // short records first, then header faults in order, then length, then crc
      if (len < MIN_LEN)                r.status = ST_LENGTH;
      else if (rec_faults[FLT_MAGIC])   r.status = ST_MAGIC;
      else if (rec_faults[FLT_VERSION]) r.status = ST_VERSION;
      else if (rec_faults[FLT_COLOR])   r.status = ST_COLOR;
      else if (rec_faults[FLT_COUNT])   r.status = ST_COUNT;
      else if (len != want_len)         r.status = ST_LENGTH;
      else if (~rec_crc != rec_tail)    r.status = ST_CRC;
      else                              r.status = ST_OK;
      r.is_verdict = 1'b1;
      r.final_flag = 1'b1;
      produced     = 1'b1;
      clear_record_model();
    end
  endtask

  task automatic report_err(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    err_count++;
  endtask

  task automatic check_field(input string name, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want)
      report_err($sformatf("result beat %0d, %s: got %0h, want %0h",
                           beats_checked, name, got, want));
  endtask

  task automatic check_result(input res_beat_t got);
    res_beat_t want;
    if (expected_results.size() == 0) begin
      report_err($sformatf("result beat %0d with nothing expected", beats_checked));
    end else begin
      want = expected_results.pop_front();
      check_field("is_verdict",       got.is_verdict,       want.is_verdict);
      check_field("move_word",        got.move_word,        want.move_word);
      check_field("move_index",       got.move_index,       want.move_index);
      check_field("player_color",     got.player_color,     want.player_color);
      check_field("move_total",       got.move_total,       want.move_total);
      check_field("generation_value", got.generation_value, want.generation_value);
      check_field("seed_value",       got.seed_value,       want.seed_value);
      check_field("status",           got.status,           want.status);
      check_field("final_flag",       got.final_flag,       want.final_flag);
      if (want.is_verdict) verdict_mix[want.status]++;
      else moves_checked++;
    end
    beats_checked++;
  endtask

  // config writes are driven at the falling edge and copied into the model
  task automatic write_cfg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] value);
    cfg_we   = 1'b1;
    cfg_idx  = idx;
    cfg_data = value;
    @(negedge clk_i);
    cfg_we = 1'b0;
    if (idx == CFG_FORMAT_VERSION) model_version = value[7:0];
    else model_max_moves = value;
  endtask

  // lay out one record in record_bytes, header fields then moves then checksum
  task automatic build_record(input rec_kind_e kind, input int n, input fill_e fill);
    int          words;
    int          at;
    int          keep;
    logic [15:0] cnt;
    logic [15:0] over_cnt;
    logic [7:0]  ver;
    logic [7:0]  color;
    logic [31:0] c;
    record_bytes.delete();
    if (kind == REC_NOISE) begin
      repeat ($urandom_range(1, 40)) record_bytes.push_back(8'($urandom_range(0, 255)));
      return;
    end
    words = (kind == REC_SHORT || kind == REC_LONG) ? 0 : n;
    cnt   = 16'(words);
    ver   = model_version;
    color = (fill == FILL_ONES) ? 8'd1 :
            (fill == FILL_ZERO) ? 8'd0 : 8'($urandom_range(0, 1));
    // a count above max_moves; only meaningful while max_moves is below the top
    over_cnt = $urandom_range(0, 1) ? 16'hFFFF
                                    : 16'($urandom_range(int'(model_max_moves) + 1, 65535));
    case (kind)
      REC_VERSION: ver = model_version ^ 8'($urandom_range(1, 255));
      REC_COLOR:   color = 8'($urandom_range(2, 255));
      REC_COUNT:   cnt = over_cnt;
      REC_TRUNC: begin
        // header promises at least the words the body carries (often the max itself)
        cnt = $urandom_range(0, 1) ? model_max_moves
                                   : 16'($urandom_range(words, int'(model_max_moves)));
        if (cnt < 16'(words)) cnt = 16'(words);
      end
      REC_MULTI: begin
        ver   = model_version ^ 8'($urandom_range(1, 255));
        color = 8'($urandom_range(2, 255));
        if (model_max_moves != 16'hFFFF) cnt = over_cnt;
      end
      default: ;
    endcase
    for (int i = 0; i < 4; i++) record_bytes.push_back(record_magic[i]);
    record_bytes.push_back(ver);
    record_bytes.push_back(color);
    record_bytes.push_back(cnt[7:0]);
    record_bytes.push_back(cnt[15:8]);
    repeat (12) record_bytes.push_back(fill_byte(fill));
    repeat (2 * words) record_bytes.push_back(fill_byte(fill));
    if (kind == REC_MAGIC || kind == REC_MULTI) begin
      at = $urandom_range(0, 3);
      record_bytes[at] = record_bytes[at] ^ 8'($urandom_range(1, 255));
    end
    c = CRC_ONES;
    foreach (record_bytes[i]) c = crc_next(c, record_bytes[i]);
    c = ~c;
    for (int i = 0; i < 4; i++) record_bytes.push_back(c[8*i +: 8]);
    case (kind)
      REC_CRC: begin
        at = $urandom_range(8, record_bytes.size() - 1);
        record_bytes[at] = record_bytes[at] ^ (8'd1 << $urandom_range(0, 7));
      end
      REC_SURPLUS:
        repeat ($urandom_range(1, 3)) record_bytes.push_back(8'($urandom_range(0, 255)));
      REC_MOVE_LAST: repeat (4) void'(record_bytes.pop_back());
      REC_SHORT: begin
        keep = (n > 0) ? n : $urandom_range(1, 23);
        while (record_bytes.size() > keep) void'(record_bytes.pop_back());
      end
      REC_LONG:
        while (record_bytes.size() < LONG_RECORD_BYTES)
          record_bytes.push_back(8'($urandom_range(0, 255)));
      default: ;
    endcase
  endtask

  // offer one byte, wait for the handshake, then predict what it causes
  task automatic send_byte(input logic [7:0] b, input logic last,
                           input bit fix_en, input status_e fix_st);
    int        gap;
    bit        produced;
    res_beat_t r;
    gap = tx_idle ? $urandom_range(0, 12) : 0;
    in_ch.valid = 1'b0;
    repeat (gap) @(negedge clk_i);
    in_ch.valid   = 1'b1;
    in_ch.payload = {b, last};
    do @(posedge clk_i); while (in_ch.ready !== 1'b1);
    predict_beat(b, last, produced, r);
    if (produced) begin
      // directed rows pin the verdict status to the value typed in the plan
      if (last && fix_en) r.status = fix_st;
      expected_results.push_back(r);
    end
    bytes_sent++;
    @(negedge clk_i);
    in_ch.valid = 1'b0;
  endtask

  task automatic run_record(input rec_kind_e kind, input int n, input fill_e fill,
                            input bit fix_en, input status_e fix_st);
    int last_idx;
    build_record(kind, n, fill);
    // most records idle at random, some run back to back; the long one never idles
    tx_idle = (kind != REC_LONG) && ($urandom_range(0, 3) != 0);
    rx_idle = (kind != REC_LONG) && ($urandom_range(0, 3) != 0);
    last_idx = record_bytes.size() - 1;
    for (int i = 0; i <= last_idx; i++)
      send_byte(record_bytes[i], i == last_idx, fix_en, fix_st);
    records_sent++;
  endtask

  // mostly well-formed records with random content, the rest faulty or noise
  task automatic random_record();
    int        pick;
    int        cap;
    int        n;
    rec_kind_e kind;
    cap  = (model_max_moves < 16'd12) ? int'(model_max_moves) : 12;
    n    = $urandom_range(0, cap);
    pick = $urandom_range(0, 99);
    if (pick < 55)      kind = REC_GOOD;
    else if (pick < 60) kind = REC_TRUNC;
    else if (pick < 64) kind = REC_MAGIC;
    else if (pick < 68) kind = REC_VERSION;
    else if (pick < 72) kind = REC_COLOR;
    else if (pick < 76) kind = (model_max_moves == 16'hFFFF) ? REC_GOOD : REC_COUNT;
    else if (pick < 80) kind = REC_SURPLUS;
    else if (pick < 84) kind = REC_MOVE_LAST;
    else if (pick < 88) kind = REC_CRC;
    else if (pick < 92) kind = REC_SHORT;
    else if (pick < 96) kind = REC_NOISE;
    else                kind = REC_MULTI;
    if (kind == REC_SHORT) n = 0;
    run_record(kind, n, FILL_RAND, 1'b0, ST_OK);
  endtask

  // sender pause: let every expected beat come back, then a few spare cycles
  task automatic wait_drained();
    while (expected_results.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // result side: random stalls, one long hold-off on request
  initial begin
    int stall;
    out_ch.ready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_ch.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_req = 1'b0;
      end
      stall = rx_idle ? $urandom_range(0, 12) : 0;
      out_ch.ready = 1'b0;
      repeat (stall) @(negedge clk_i);
      out_ch.ready = 1'b1;
      do @(posedge clk_i); while (out_ch.valid !== 1'b1);
      check_result(out_ch.payload);
    end
  end

  // hang detector: any beat on either channel resets the count
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
      $display("timeout: no beat for %0d cycles, %0d results outstanding",
               QUIET_LIMIT, expected_results.size());
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int base;
    rst_ni        = 1'b0;
    cfg_we        = 1'b0;
    cfg_idx       = CFG_FORMAT_VERSION;
    cfg_data      = '0;
    in_ch.valid   = 1'b0;
    in_ch.payload = '0;
    model_version   = FORMAT_VERSION_RST;
    model_max_moves = MAX_MOVES_RST;
    clear_record_model();
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed records under the reset configuration
    foreach (directed_plan[i])
      run_record(directed_plan[i].kind, directed_plan[i].n, directed_plan[i].fill,
                 1'b1, directed_plan[i].verdict);
    wait_drained();

    // random phases under several configurations, the extremes among them
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        1: begin
          write_cfg(CFG_FORMAT_VERSION, 16'd0);
          write_cfg(CFG_MAX_MOVES, 16'd0);
        end
        2: begin
          write_cfg(CFG_FORMAT_VERSION, 16'd255);
          write_cfg(CFG_MAX_MOVES, 16'hFFFF);
        end
        3: begin
          write_cfg(CFG_FORMAT_VERSION, 16'($urandom_range(0, 255)));
          write_cfg(CFG_MAX_MOVES, 16'($urandom_range(0, 40)));
        end
        4: begin
          write_cfg(CFG_FORMAT_VERSION, 16'(FORMAT_VERSION_RST));
          write_cfg(CFG_MAX_MOVES, MAX_MOVES_RST);
        end
        default: ;
      endcase
      // back the result side up so the block stalls its input
      if (phase == 0 || phase == 2) hold_req = 1'b1;
      base = bytes_sent;
      while (bytes_sent - base < PHASE_BYTES) random_record();
      wait_drained();
    end

    repeat (8) @(posedge clk_i);
    if (expected_results.size() != 0)
      report_err($sformatf("%0d expected results never arrived", expected_results.size()));

    $display("summary: %0d records in %0d byte beats, %0d result beats checked (%0d moves)",
             records_sent, bytes_sent, beats_checked, moves_checked);
    $display("verdicts ok/len/magic/ver/color/count/crc: %0d/%0d/%0d/%0d/%0d/%0d/%0d",
             verdict_mix[ST_OK], verdict_mix[ST_LENGTH], verdict_mix[ST_MAGIC],
             verdict_mix[ST_VERSION], verdict_mix[ST_COLOR], verdict_mix[ST_COUNT],
             verdict_mix[ST_CRC]);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
